/* sv/ghist_pkg.sv */
// shared constants, types and helper functions of the oriented-gradient histogram
// no dependencies
package ghist_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int CELL_EDGE  = 16;
	localparam int BIN_COUNT  = 8;
	localparam int ADDR_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);
	localparam int SIZE_W     = 11;
	localparam int PIX_W      = 24;
	localparam int SUM_W      = 40;
	localparam int SQ_W       = 25;
	localparam int ROOT_W     = 13;
	localparam int BIN_W      = $clog2(BIN_COUNT);

	// configuration register indexes
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef logic signed [8:0] grad_t;

	// size register clamped to [2, maxv]
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v < SIZE_W'(2)) r = SIZE_W'(2);
		else if (v > maxv) r = maxv;
		else r = v;
		return r;
	endfunction

	// 45 degree sector from signs and magnitude compare
	function automatic logic [BIN_W-1:0] sector(input grad_t gx, input grad_t gy);
		grad_t ax;
		grad_t ay;
		logic [BIN_W-1:0] b;
		ax = gx < 0 ? -gx : gx;
		ay = gy < 0 ? -gy : gy;
		if (gy >= 0) begin
			if (gx > 0) b = (gy < gx) ? BIN_W'(0) : BIN_W'(1);
			else if (gy == 0) b = (gx == 0) ? BIN_W'(0) : BIN_W'(4);
			else b = (ax < gy) ? BIN_W'(2) : BIN_W'(3);
		end else if (gx < 0) begin
			b = (ay < ax) ? BIN_W'(4) : BIN_W'(5);
		end else begin
			b = (gx < ay) ? BIN_W'(6) : BIN_W'(7);
		end
		return b;
	endfunction

endpackage

/* sv/ghist_isqrt.sv */
// iterative integer square root, two operand bits per cycle
// depends on ghist_pkg
module ghist_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ghist_pkg::SQ_W-1:0]     operand,
	output logic                           done,
	output logic [ghist_pkg::ROOT_W-1:0]   root
);

	logic                         running_q;
	logic                         done_q;
	logic [ghist_pkg::SQ_W-1:0]   v_q;
	logic [ghist_pkg::SQ_W:0]     res_q;
	logic [ghist_pkg::SQ_W-1:0]   bit_q;
	logic [ghist_pkg::SQ_W:0]     trial;

	assign trial = res_q + {1'b0, bit_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				running_q <= 1'b1;
			end else if (running_q && bit_q[0]) begin
				running_q <= 1'b0;
				done_q    <= 1'b1;
			end
		end
	end

	// restoring square root step
	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= operand;
			res_q <= '0;
			bit_q <= ghist_pkg::SQ_W'(1) << (ghist_pkg::SQ_W - 1);
		end else if (running_q) begin
			if ({1'b0, v_q} >= trial) begin
				v_q   <= v_q - trial[ghist_pkg::SQ_W-1:0];
				res_q <= (res_q >> 1) + {1'b0, bit_q};
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ghist_pkg::ROOT_W-1:0];

endmodule

/* sv/gradient_orientation_histogram.sv */
// top level of the eight-bin oriented-gradient histogram: row memories, sequencer, bins
// depends on ghist_pkg and ghist_isqrt
//
//  channel | signals                               | direction
//  pixel   | pixel_valid/ready, chan_a/b/c         | in, one request per pixel
//  bins    | bin_valid/ready, bin_number/total/last| out, 8 requests after last pixel
//  config  | cfg_we, cfg_addr, cfg_data            | in, write only
//
// a pixel steps through the row-memory read states RD1, RD2, RD3 (one read port on the previous row),
// then per channel gradient only a CALC step if it falls outside the crop, else CALC, START and SQRT,
// waiting on the 13-step square root unit; up to 6 channel gradients per pixel
// the last pixel of a frame then shows 8 bin requests, one per cycle while taken
// reset clears counters, bins and sizes (640 x 480); row memories need no clearing
// a stalled bin request holds the block; no pixel is taken until all bins are out
module gradient_orientation_histogram (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               pixel_valid,
	output logic                               pixel_ready,
	input  logic [7:0]                         chan_a,
	input  logic [7:0]                         chan_b,
	input  logic [7:0]                         chan_c,
	output logic                               bin_valid,
	input  logic                               bin_ready,
	output logic [ghist_pkg::BIN_W-1:0]        bin_number,
	output logic [ghist_pkg::SUM_W-1:0]        bin_total,
	output logic                               last_bin,
	input  logic                               cfg_we,
	input  logic                               cfg_addr,
	input  logic [ghist_pkg::SIZE_W-1:0]       cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD1   = 4'd1;
	localparam logic [3:0] S_RD2   = 4'd2;
	localparam logic [3:0] S_RD3   = 4'd3;
	localparam logic [3:0] S_CALC  = 4'd4;
	localparam logic [3:0] S_START = 4'd5;
	localparam logic [3:0] S_SQRT  = 4'd6;
	localparam logic [3:0] S_OUT   = 4'd7;

	localparam int AW = ghist_pkg::ADDR_W;
	localparam int RW = ghist_pkg::ROW_W;
	localparam int SW = ghist_pkg::SIZE_W;
	localparam int PW = ghist_pkg::PIX_W;

	logic [3:0]                      state_q;
	logic [SW-1:0]                   width_q, height_q;
	logic [AW-1:0]                   col_q;
	logic [RW-1:0]                   row_q;
	logic [SW-1:0]                   w_q, h_q;
	logic [AW-1:0]                   x_q;
	logic [RW-1:0]                   y_q;
	logic                            frame_end_q;
	logic [PW-1:0]                   cur_q, left_q, recent_q;
	logic [PW-1:0]                   above_q, two_up_q, right_q, left2_q;
	logic [2:0]                      ch_q;
	logic [ghist_pkg::BIN_W-1:0]     bin_q;
	logic [ghist_pkg::SQ_W-1:0]      sq_q;
	logic [ghist_pkg::BIN_W-1:0]     out_idx_q;
	logic [ghist_pkg::SUM_W-1:0]     sums_q [ghist_pkg::BIN_COUNT];

	logic [PW-1:0]                   prev_mem [ghist_pkg::MAX_WIDTH];
	logic [PW-1:0]                   older_mem [ghist_pkg::MAX_WIDTH];
	logic [PW-1:0]                   prev_rd_q, older_rd_q;
	logic [AW-1:0]                   prev_raddr;
	logic                            prev_re;

	logic                            accept;
	logic [SW-1:0]                   w_c, h_c;
	logic [AW-1:0]                   x_c;
	logic [RW-1:0]                   y_c;
	logic                            row_end_c, frame_end_c;
	logic [SW-1:0]                   wc, hc;
	logic                            en0, en1, grp1, ch_en;
	logic [1:0]                      lane;
	logic [7:0]                      p_cur, p_right, p_left, p_two, p_left2;
	ghist_pkg::grad_t                gx, gy;
	logic signed [17:0]              gxx, gyy;
	logic [17:0]                     sqsum;
	logic                            sq_start, sq_done;
	logic [ghist_pkg::ROOT_W-1:0]    sq_root;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SW'(640);
			height_q <= SW'(480);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				ghist_pkg::REG_WIDTH:  width_q  <= cfg_data;
				ghist_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// position of the incoming pixel
	always_comb begin
		w_c = ghist_pkg::clamp_size(width_q, SW'(ghist_pkg::MAX_WIDTH));
		h_c = ghist_pkg::clamp_size(height_q, SW'(ghist_pkg::MAX_HEIGHT));
		x_c = ({1'b0, col_q} >= w_c) ? AW'(w_c - SW'(1)) : col_q;
		y_c = (SW'(row_q) >= h_c) ? RW'(h_c - SW'(1)) : row_q;
		row_end_c   = {1'b0, x_c} >= w_c - SW'(1);
		frame_end_c = row_end_c && (SW'(y_c) >= h_c - SW'(1));
	end

	assign pixel_ready = (state_q == S_IDLE);
	assign accept      = pixel_valid && pixel_ready;

	// previous row read address per sequencer step
	always_comb begin
		prev_re    = 1'b1;
		prev_raddr = x_c;
		unique case (state_q)
			S_IDLE:  prev_raddr = x_c;
			S_RD1:   prev_raddr = x_q + AW'(1);
			S_RD2:   prev_raddr = x_q - AW'(2);
			default: prev_re    = 1'b0;
		endcase
	end

	// row memories
	always_ff @(posedge clk) begin
		if (state_q == S_RD3) prev_mem[x_q] <= cur_q;
		if (prev_re) prev_rd_q <= prev_mem[prev_raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RD3) older_mem[x_q] <= above_q;
		if (accept) older_rd_q <= older_mem[x_c];
	end

	// gradient of the current channel step
	always_comb begin
		wc   = w_q & ~SW'(ghist_pkg::CELL_EDGE - 1);
		hc   = h_q & ~SW'(ghist_pkg::CELL_EDGE - 1);
		en0  = (y_q != '0) && (SW'(x_q) < wc) && (SW'(y_q - RW'(1)) < hc);
		en1  = (SW'(y_q) == h_q - SW'(1)) && (x_q != '0) &&
			(SW'(x_q - AW'(1)) < wc) && (SW'(y_q) < hc);
		grp1 = ch_q > 3'd2;
		lane = grp1 ? 2'(ch_q - 3'd3) : ch_q[1:0];
		p_cur   = cur_q[lane*8 +: 8];
		p_right = right_q[lane*8 +: 8];
		p_left  = left_q[lane*8 +: 8];
		p_two   = two_up_q[lane*8 +: 8];
		p_left2 = left2_q[lane*8 +: 8];
		if (grp1) begin
			ch_en = en1;
			gx = (x_q != AW'(1)) ? $signed({1'b0, p_cur}) - $signed({1'b0, p_left2}) : '0;
			gy = '0;
		end else begin
			ch_en = en0;
			gx = (x_q != '0 && SW'(x_q) != w_q - SW'(1)) ?
				$signed({1'b0, p_right}) - $signed({1'b0, p_left}) : '0;
			gy = (y_q != RW'(1)) ? $signed({1'b0, p_cur}) - $signed({1'b0, p_two}) : '0;
		end
		gxx   = gx * gx;
		gyy   = gy * gy;
		sqsum = 18'(gxx) + 18'(gyy);
	end

	assign sq_start = (state_q == S_START);

	ghist_isqrt u_isqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.operand (sq_q),
		.done    (sq_done),
		.root    (sq_root)
	);

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			recent_q  <= '0;
			ch_q      <= '0;
			out_idx_q <= '0;
			for (int i = 0; i < ghist_pkg::BIN_COUNT; i++) sums_q[i] <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) begin
					state_q <= S_RD1;
					if (x_c == '0 && y_c == '0)
						for (int i = 0; i < ghist_pkg::BIN_COUNT; i++) sums_q[i] <= '0;
					if (row_end_c) begin
						col_q <= '0;
						row_q <= frame_end_c ? '0 : y_c + RW'(1);
					end else begin
						col_q <= x_c + AW'(1);
					end
				end
				S_RD1: state_q <= S_RD2;
				S_RD2: state_q <= S_RD3;
				S_RD3: begin
					recent_q <= above_q;
					ch_q     <= '0;
					state_q  <= S_CALC;
				end
				S_CALC: begin
					if (ch_en) state_q <= S_START;
					else if (ch_q == 3'd5) state_q <= frame_end_q ? S_OUT : S_IDLE;
					else ch_q <= ch_q + 3'd1;
					out_idx_q <= '0;
				end
				S_START: state_q <= S_SQRT;
				S_SQRT: if (sq_done) begin
					sums_q[bin_q] <= sums_q[bin_q] + ghist_pkg::SUM_W'(sq_root);
					if (ch_q == 3'd5) begin
						state_q <= frame_end_q ? S_OUT : S_IDLE;
					end else begin
						ch_q    <= ch_q + 3'd1;
						state_q <= S_CALC;
					end
				end
				S_OUT: if (bin_ready) begin
					out_idx_q <= out_idx_q + ghist_pkg::BIN_W'(1);
					if (out_idx_q == ghist_pkg::BIN_W'(ghist_pkg::BIN_COUNT - 1))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// pixel and neighbor payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q       <= {chan_c, chan_b, chan_a};
			left_q      <= recent_q;
			x_q         <= x_c;
			y_q         <= y_c;
			w_q         <= w_c;
			h_q         <= h_c;
			frame_end_q <= frame_end_c;
		end
		if (state_q == S_RD1) begin
			above_q  <= prev_rd_q;
			two_up_q <= older_rd_q;
		end
		if (state_q == S_RD2)
			right_q <= ({1'b0, x_q} + SW'(1) < w_q) ? prev_rd_q : '0;
		if (state_q == S_RD3)
			left2_q <= prev_rd_q;
		if (state_q == S_CALC) begin
			sq_q  <= {sqsum[16:0], 8'd0};
			bin_q <= ghist_pkg::sector(gx, gy);
		end
	end

	// bin requests
	assign bin_valid  = (state_q == S_OUT);
	assign bin_number = out_idx_q;
	assign bin_total  = sums_q[out_idx_q];
	assign last_bin   = (out_idx_q == ghist_pkg::BIN_W'(ghist_pkg::BIN_COUNT - 1));

endmodule

/* tb/sv/gradient_orientation_histogram_tb.sv */
// self-checking testbench of the oriented-gradient histogram: streams frames of pixels,
// predicts the eight bin totals per frame and checks every bin request
// depends on ghist_pkg and gradient_orientation_histogram
module gradient_orientation_histogram_tb;

	localparam int RUN_LIMIT = 4000000;

	typedef struct packed {
		logic [ghist_pkg::BIN_W-1:0] number;
		logic [ghist_pkg::SUM_W-1:0] total;
		logic                        last;
	} bin_req_t;

	logic                           clk;
	logic                           arst_n;
	logic                           pixel_valid;
	logic                           pixel_ready;
	logic [7:0]                     chan_a;
	logic [7:0]                     chan_b;
	logic [7:0]                     chan_c;
	logic                           bin_valid;
	logic                           bin_ready;
	logic [ghist_pkg::BIN_W-1:0]    bin_number;
	logic [ghist_pkg::SUM_W-1:0]    bin_total;
	logic                           last_bin;
	logic                           cfg_we;
	logic                           cfg_addr;
	logic [ghist_pkg::SIZE_W-1:0]   cfg_data;

	gradient_orientation_histogram dut (.*);

	// pixels waiting to be sent and bins waiting to come back
	logic [ghist_pkg::PIX_W-1:0] pixel_queue[$];
	bin_req_t                    bins_due[$];
	int                          fail_count;
	int                          cycle_count;
	bit                          pixel_taken;

	// histogram predictor state
	logic [ghist_pkg::PIX_W-1:0]  line_above[ghist_pkg::MAX_WIDTH];
	logic [ghist_pkg::PIX_W-1:0]  line_two_up[ghist_pkg::MAX_WIDTH];
	logic [ghist_pkg::PIX_W-1:0]  left_above;
	logic [ghist_pkg::SUM_W-1:0]  hist[ghist_pkg::BIN_COUNT];
	int                           next_col;
	int                           next_row;
	logic [ghist_pkg::SIZE_W-1:0] width_reg;
	logic [ghist_pkg::SIZE_W-1:0] height_reg;

	// clock; reset is driven by the stimulus block
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int limit_size(input logic [ghist_pkg::SIZE_W-1:0] v, input int maxv);
		int r;
		r = int'(v);
		if (r < 2) r = 2;
		if (r > maxv) r = maxv;
		return r;
	endfunction

	// floor square root by bit-by-bit trial
	function automatic int floor_root(input int v);
		int r;
		int trial;
		r = 0;
		for (int b = ghist_pkg::ROOT_W - 1; b >= 0; b--) begin
			trial = r | (1 << b);
			if (trial * trial <= v) r = trial;
		end
		return r;
	endfunction

	// 45 degree orientation sector of one gradient
	function automatic int orientation(input int gx, input int gy);
		int ax;
		int ay;
		ax = (gx < 0) ? -gx : gx;
		ay = (gy < 0) ? -gy : gy;
		if (gx == 0 && gy == 0) return 0;
		if (gy >= 0) begin
			if (gx > 0) return (gy < gx) ? 0 : 1;
			if (gy == 0) return 4;
			return (ax < gy) ? 2 : 3;
		end
		if (gx < 0) return (ay < ax) ? 4 : 5;
		return (gx < ay) ? 6 : 7;
	endfunction

	// add the three channel gradients of one pixel position
	task automatic add_gradients(input int cy, input int cx, input int w, input int h,
			input bit x_on, input logic [ghist_pkg::PIX_W-1:0] hx,
			input logic [ghist_pkg::PIX_W-1:0] lx,
			input bit y_on, input logic [ghist_pkg::PIX_W-1:0] hy,
			input logic [ghist_pkg::PIX_W-1:0] ly);
		int gx;
		int gy;
		int s;
		if (cx >= (w / ghist_pkg::CELL_EDGE) * ghist_pkg::CELL_EDGE ||
				cy >= (h / ghist_pkg::CELL_EDGE) * ghist_pkg::CELL_EDGE) return;
		for (int k = 0; k < 3; k++) begin
			gx = x_on ? int'(hx[8*k +: 8]) - int'(lx[8*k +: 8]) : 0;
			gy = y_on ? int'(hy[8*k +: 8]) - int'(ly[8*k +: 8]) : 0;
			s = orientation(gx, gy);
			hist[s] = hist[s] + ghist_pkg::SUM_W'(floor_root((gx * gx + gy * gy) * 256));
		end
	endtask

	// advance the predictor by one accepted pixel
	task automatic predict_pixel(input logic [ghist_pkg::PIX_W-1:0] cur);
		int w;
		int h;
		int x;
		int y;
		logic [ghist_pkg::PIX_W-1:0] above;
		logic [ghist_pkg::PIX_W-1:0] two_up;
		logic [ghist_pkg::PIX_W-1:0] right_px;
		bin_req_t r;
		w = limit_size(width_reg, ghist_pkg::MAX_WIDTH);
		h = limit_size(height_reg, ghist_pkg::MAX_HEIGHT);
		x = (next_col >= w) ? w - 1 : next_col;
		y = (next_row >= h) ? h - 1 : next_row;
		if (x == 0 && y == 0)
			for (int b = 0; b < ghist_pkg::BIN_COUNT; b++) hist[b] = '0;
		above = line_above[x];
		two_up = line_two_up[x];
		right_px = (x + 1 < w) ? line_above[x+1] : '0;
		if (y >= 1)
			add_gradients(y - 1, x, w, h, x != 0 && x != w - 1, right_px, left_above,
				y - 1 != 0, cur, two_up);
		// bottom row: left neighbour gets its horizontal gradient now
		if (y == h - 1 && x >= 1)
			add_gradients(y, x - 1, w, h, x - 1 != 0, cur,
				(x >= 2) ? line_above[x-2] : '0, 1'b0, '0, '0);
		left_above = above;
		line_two_up[x] = above;
		line_above[x] = cur;
		if (x >= w - 1) begin
			next_col = 0;
			if (y >= h - 1) begin
				next_row = 0;
				for (int b = 0; b < ghist_pkg::BIN_COUNT; b++) begin
					r.number = ghist_pkg::BIN_W'(b);
					r.total = hist[b];
					r.last = (b == ghist_pkg::BIN_COUNT - 1);
					bins_due = {bins_due, r};
				end
			end else begin
				next_row = (y + 1) % ghist_pkg::MAX_HEIGHT;
			end
		end else begin
			next_col = x + 1;
		end
	endtask

	// predictor reset
	initial begin
		for (int i = 0; i < ghist_pkg::MAX_WIDTH; i++) begin
			line_above[i] = '0;
			line_two_up[i] = '0;
		end
		for (int b = 0; b < ghist_pkg::BIN_COUNT; b++) hist[b] = '0;
		left_above = '0;
		next_col = 0;
		next_row = 0;
		width_reg = ghist_pkg::SIZE_W'(640);
		height_reg = ghist_pkg::SIZE_W'(480);
	end

	// pixel request taken at this rising edge
	always @(posedge clk) begin
		pixel_taken <= pixel_valid && pixel_ready;
	end

	// monitor: config writes, pixel requests, bin requests, run limit
	always @(posedge clk) begin
		bin_req_t e;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (cycle_count > RUN_LIMIT) begin
				$display("%0t timeout", $time);
				$display("CHECKS FAILED");
				$finish;
			end
			if (cfg_we) begin
				if (cfg_addr == ghist_pkg::REG_WIDTH) width_reg = cfg_data;
				else height_reg = cfg_data;
			end
			if (pixel_valid && pixel_ready) predict_pixel({chan_c, chan_b, chan_a});
			if (bin_valid && bin_ready) begin
				if (bins_due.size() == 0) begin
					$display("%0t unexpected bin request: bin %0d total %0d last %0b",
						$time, bin_number, bin_total, last_bin);
					fail_count++;
				end else begin
					e = bins_due.pop_front();
					if (bin_number !== e.number) begin
						$display("%0t bin_number expected %0d actual %0d",
							$time, e.number, bin_number);
						fail_count++;
					end
					if (bin_total !== e.total) begin
						$display("%0t bin_total of bin %0d expected %0d actual %0d",
							$time, e.number, e.total, bin_total);
						fail_count++;
					end
					if (last_bin !== e.last) begin
						$display("%0t last_bin of bin %0d expected %0b actual %0b",
							$time, e.number, e.last, last_bin);
						fail_count++;
					end
				end
			end
		end
	end

	// pixel driver: bursts with random gaps
	int  burst_left;
	int  gap_left;
	always @(negedge clk) begin
		if (!arst_n) begin
			pixel_valid <= 1'b0;
		end else if (!pixel_valid || pixel_taken) begin
			// previous request, if any, was taken at the last rising edge
			if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				pixel_valid <= 1'b0;
			end else if (pixel_queue.size() > 0) begin
				{chan_c, chan_b, chan_a} <= pixel_queue.pop_front();
				pixel_valid <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 40);
					gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				pixel_valid <= 1'b0;
			end
		end
	end

	// bin receiver: stall pattern changes when its mode counter runs out, one long hold-off
	// while more pixels are still waiting to be sent
	int  stall_mode;
	int  mode_cycles;
	int  hold_left;
	bit  hold_done;
	always @(negedge clk) begin
		if (!arst_n) begin
			bin_ready <= 1'b0;
		end else begin
			if (mode_cycles == 0) begin
				stall_mode <= $urandom_range(0, 2);
				mode_cycles <= 64;
			end else begin
				mode_cycles <= mode_cycles - 1;
			end
			if (!hold_done && bin_valid && pixel_queue.size() > 0) begin
				hold_done <= 1'b1;
				hold_left <= 400;
				bin_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				bin_ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: bin_ready <= 1'b1;
					1: bin_ready <= $urandom_range(0, 1);
					default: bin_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// pixel value biased toward the channel extremes
	function automatic logic [7:0] pick_level();
		case ($urandom_range(0, 3))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom);
		endcase
	endfunction

	// append one pixel to the send queue
	task automatic queue_pixel(input logic [ghist_pkg::PIX_W-1:0] px);
		pixel_queue = {pixel_queue, px};
	endtask

	task automatic queue_frame(input int w, input int h);
		for (int i = 0; i < w * h; i++)
			queue_pixel({pick_level(), pick_level(), pick_level()});
	endtask

	// hold the sender until the block has drained
	task automatic wait_drained();
		while (pixel_queue.size() > 0 || pixel_valid || bins_due.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_data <= ghist_pkg::SIZE_W'(value);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_size(input int w_val, input int h_val);
		write_reg(ghist_pkg::REG_WIDTH, w_val);
		write_reg(ghist_pkg::REG_HEIGHT, h_val);
	endtask

	// stimulus and end of run
	initial begin
		int w;
		int h;
		int sent_pixels;
		int frames;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		chan_a = '0;
		chan_b = '0;
		chan_c = '0;
		bin_ready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = ghist_pkg::REG_WIDTH;
		cfg_data = '0;
		fail_count = 0;
		cycle_count = 0;
		pixel_taken = 1'b0;
		burst_left = 0;
		gap_left = 0;
		stall_mode = 0;
		mode_cycles = 0;
		hold_left = 0;
		hold_done = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// smallest frame, channel extremes
		set_size(2, 2);
		queue_pixel(24'h000000);
		queue_pixel(24'hFFFFFF);
		queue_pixel(24'hFF00FF);
		queue_pixel(24'h00FF00);
		wait_drained();
		// sizes below two clamp up
		set_size(0, 1);
		queue_pixel(24'hFFFFFF);
		queue_pixel(24'h000000);
		queue_pixel(24'h00FF00);
		queue_pixel(24'hFF00FF);
		wait_drained();
		// one full cell
		set_size(16, 16);
		queue_frame(16, 16);
		wait_drained();
		sent_pixels = 264;

		// random frames, small ones or a little more than one cell
		frames = 0;
		while (sent_pixels < 470) begin
			if (frames == 0 || sent_pixels + 288 > 520 || $urandom_range(0, 1) == 0) begin
				w = $urandom_range(2, 8);
				h = $urandom_range(2, 8);
			end else begin
				w = $urandom_range(16, 18);
				h = 16;
			end
			set_size(w, h);
			queue_frame(w, h);
			// small frames sometimes get a second frame of the same size back to back
			if (w * h <= 64 && (frames == 0 || $urandom_range(0, 2) == 0)) begin
				queue_frame(w, h);
				sent_pixels += w * h;
				frames++;
			end
			sent_pixels += w * h;
			frames++;
			wait_drained();
		end

		repeat (200) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

/* files.f */
sv/ghist_pkg.sv
sv/ghist_isqrt.sv
sv/gradient_orientation_histogram.sv
tb/sv/gradient_orientation_histogram_tb.sv
